// ===== rtl/vctr_pkg.sv =====
`default_nettype none

package vctr_pkg;

	// Field widths.
	localparam int POINT_BITS    = 16;
	localparam int VOXEL_ID_BITS = 16;
	localparam int COUNT_BITS    = 24;
	localparam int CMD_BITS      = 2;

	// Point-to-voxel table depth.
	localparam int MAX_POINTS = 1 << POINT_BITS;

	// Saturation value of the kept-triangle counter.
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_MAP = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_TRI = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_END = 2'd2;

	// Result kinds.
	localparam logic KIND_TRI   = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	// Read address selects for the table port.
	localparam logic [1:0] SEL_A_IN = 2'd0;
	localparam logic [1:0] SEL_B    = 2'd1;
	localparam logic [1:0] SEL_C    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       map_wr;   // write the table from the input ports
		logic       rd_en;    // read the table this cycle
		logic [1:0] rd_sel;   // which vertex addresses the read
		logic       cap_idx;  // capture vertex b and c indices
		logic       cap_a;    // capture the voxel of vertex a
		logic       cap_b;    // capture the voxel of vertex b
		logic       finish;   // compare and emit a triangle
		logic       report;   // emit the count and clear it
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/vertex_cluster_triangle_remap_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      cmd, point_index, voxel_id, vertex_a..c
// result    out        result_valid, one cycle   kind, out_a, out_b, out_c, tri_count
//
// A map write or an end-of-mesh transaction completes without raising busy.
// A triangle transaction does one read of the single-port point-to-voxel
// table per vertex, then a compare step; busy stays high through the compare.
// A result (kept triangle or count) is registered in the cycle after the final step; the receiver cannot stall.
// Reset clears the counter and the controller; table contents are undefined until written.

module vertex_cluster_triangle_remap_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [vctr_pkg::CMD_BITS-1:0]         cmd,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       point_index,
	input  wire logic [vctr_pkg::VOXEL_ID_BITS-1:0]    voxel_id,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_a,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_b,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_c,
	output logic                                       result_valid,
	output logic                                       kind,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_a,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_b,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_c,
	output logic [vctr_pkg::COUNT_BITS-1:0]            tri_count
);

	vctr_pkg::ctl_t ctl;

	// Sequencer for the table accesses.
	vctr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Table, compare and counter.
	vctr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.point_index  (point_index),
		.voxel_id     (voxel_id),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.vertex_c     (vertex_c),
		.result_valid (result_valid),
		.kind         (kind),
		.out_a        (out_a),
		.out_b        (out_b),
		.out_c        (out_c),
		.tri_count    (tri_count)
	);

endmodule

`default_nettype wire

// ===== rtl/vctr_ctrl.sv =====
`default_nettype none

module vctr_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [vctr_pkg::CMD_BITS-1:0] cmd,
	output logic                              busy,
	output vctr_pkg::ctl_t                    ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RB   = 2'd1;
	localparam logic [1:0] ST_RC   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						vctr_pkg::CMD_MAP: begin
							ctl.map_wr = 1'b1;
						end
						vctr_pkg::CMD_TRI: begin
							ctl.rd_en   = 1'b1;
							ctl.rd_sel  = vctr_pkg::SEL_A_IN;
							ctl.cap_idx = 1'b1;
							state_d     = ST_RB;
						end
						vctr_pkg::CMD_END: begin
							ctl.report = 1'b1;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RB: begin
				ctl.cap_a  = 1'b1;
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = vctr_pkg::SEL_B;
				state_d    = ST_RC;
			end
			ST_RC: begin
				ctl.cap_b  = 1'b1;
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = vctr_pkg::SEL_C;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				ctl.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A triangle transaction walks the three lookups in order.
	a_tri_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == vctr_pkg::CMD_TRI) |=> (state_q == ST_RB))
		else $error("triangle accept did not start the lookups");

	a_tri_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RB) |=> (state_q == ST_RC) ##1 (state_q == ST_FIN))
		else $error("triangle lookups out of order");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.map_wr && ctl.rd_en))
		else $error("table port written and read in one cycle");

endmodule

`default_nettype wire

// ===== rtl/vctr_dp.sv =====
`default_nettype none

module vctr_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire vctr_pkg::ctl_t                        ctl,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       point_index,
	input  wire logic [vctr_pkg::VOXEL_ID_BITS-1:0]    voxel_id,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_a,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_b,
	input  wire logic [vctr_pkg::POINT_BITS-1:0]       vertex_c,
	output logic                                       result_valid,
	output logic                                       kind,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_a,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_b,
	output logic [vctr_pkg::VOXEL_ID_BITS-1:0]         out_c,
	output logic [vctr_pkg::COUNT_BITS-1:0]            tri_count
);

	logic [vctr_pkg::VOXEL_ID_BITS-1:0] voxel_mem [vctr_pkg::MAX_POINTS];

	logic [vctr_pkg::POINT_BITS-1:0]    addr;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] rd_q;
	logic [vctr_pkg::POINT_BITS-1:0]    idx_b_q;
	logic [vctr_pkg::POINT_BITS-1:0]    idx_c_q;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] va_q;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] vb_q;
	logic [vctr_pkg::COUNT_BITS-1:0]    count_q;
	logic [vctr_pkg::COUNT_BITS-1:0]    count_inc;
	logic                               distinct;
	logic                               valid_q;
	logic                               kind_q;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] out_a_q;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] out_b_q;
	logic [vctr_pkg::VOXEL_ID_BITS-1:0] out_c_q;
	logic [vctr_pkg::COUNT_BITS-1:0]    cnt_out_q;

	// Single table port: map writes take the input point, lookups the selected vertex.
	always_comb begin
		unique case (ctl.rd_sel)
			vctr_pkg::SEL_B: addr = idx_b_q;
			vctr_pkg::SEL_C: addr = idx_c_q;
			default:         addr = ctl.map_wr ? point_index : vertex_a;
		endcase
	end

	// Point-to-voxel table with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.map_wr) begin
			voxel_mem[addr] <= voxel_id;
		end
		if (ctl.rd_en) begin
			rd_q <= voxel_mem[addr];
		end
	end

	// Held vertex indices and looked-up voxel ids.
	always_ff @(posedge clk) begin
		if (ctl.cap_idx) begin
			idx_b_q <= vertex_b;
			idx_c_q <= vertex_c;
		end
		if (ctl.cap_a) begin
			va_q <= rd_q;
		end
		if (ctl.cap_b) begin
			vb_q <= rd_q;
		end
	end

	// The third voxel id is still in the read register when the triangle finishes.
	assign distinct  = (va_q != vb_q) && (vb_q != rd_q) && (va_q != rd_q);
	assign count_inc = (count_q == vctr_pkg::COUNT_MAX) ? count_q
		: count_q + vctr_pkg::COUNT_BITS'(1);

	// Kept-triangle counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= (ctl.finish && distinct) || ctl.report;
			if (ctl.report) begin
				count_q <= '0;
			end else if (ctl.finish && distinct) begin
				count_q <= count_inc;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctl.report) begin
			kind_q    <= vctr_pkg::KIND_COUNT;
			out_a_q   <= '0;
			out_b_q   <= '0;
			out_c_q   <= '0;
			cnt_out_q <= count_q;
		end else if (ctl.finish) begin
			kind_q    <= vctr_pkg::KIND_TRI;
			out_a_q   <= va_q;
			out_b_q   <= vb_q;
			out_c_q   <= rd_q;
			cnt_out_q <= count_inc;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign out_a        = out_a_q;
	assign out_b        = out_b_q;
	assign out_c        = out_c_q;
	assign tri_count    = cnt_out_q;

	// A kept triangle never carries two equal voxel ids.
	a_kept_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == vctr_pkg::KIND_TRI) |->
		(out_a_q != out_b_q && out_b_q != out_c_q && out_a_q != out_c_q))
		else $error("collapsed triangle emitted");

	// The report clears the counter.
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.report |=> (count_q == '0 && valid_q && kind_q == vctr_pkg::KIND_COUNT))
		else $error("count report did not clear the counter");

	// A kept triangle advances the count it reports, unless saturated.
	a_kept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && distinct) |=>
		(cnt_out_q == count_q && (count_q != '0)))
		else $error("kept triangle count mismatch");

endmodule

`default_nettype wire
